[hdl/ctabe_pkg.sv]
package ctabe_pkg;

    localparam int MAX_SIDE = 4095;

    localparam int IN_W  = 80;
    localparam int OUT_W = 8;
    localparam int CFG_W = 12;

    localparam logic [0:0] REG_COLUMNS = 1'b0;
    localparam logic [0:0] REG_ROWS    = 1'b1;

    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_HOME,
        HDR_ROW
    } hdr_t;

    // decimal component, digits MSB first, last = index of final digit
    typedef struct packed {
        logic [2:0][3:0] dig;
        logic [1:0]      last;
    } dec3_t;

    typedef struct packed {
        hdr_t            hdr;
        logic [3:0][3:0] row_dig;
        logic [1:0]      row_last;
        logic            color;
        dec3_t [5:0]     col;
        logic [3:0][7:0] utf8;
        logic [1:0]      utf8_last;
        logic            frame_end;
    } desc_t;

endpackage

[hdl/cell_to_ansi_byte_encoder_top.sv]
// Screen cells in, terminal bytes out, one byte per cycle on the master side while m_tready holds.
// A cell occupies the output for as many bytes as it causes: one to
// four for a plain character, plus 3 for the home sequence or 6 to 9 for a row
// move, plus 26 to 38 when the color pair changes or a frame begins, plus 4 after the last cell
// of a frame (at most 55). The byte sequencer in the back end sets that figure.
// The front end classifies a cell and takes a new one every cycle while its
// two-entry descriptor queue has room, so it keeps accepting while bytes drain.
// The columns and rows registers are written through the cfg channel, which
// is always ready; write them only while the block is idle.
module cell_to_ansi_byte_encoder_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // code_point[31:0], fore_rgb[55:32], back_rgb[79:56]
    input  logic [ctabe_pkg::IN_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_byte[7:0]
    output logic [ctabe_pkg::OUT_W-1:0]  m_tdata,
    output logic                         m_tlast,
    // frame_done[0]
    output logic                         m_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [ctabe_pkg::CFG_W-1:0]  cfg_data
);

    ctabe_pkg::desc_t push_desc, head_desc;
    logic             q_push, q_pop, q_full, q_empty;

    ctabe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (push_desc)
    );

    ctabe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_desc),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (head_desc),
        .empty   (q_empty)
    );

    ctabe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_desc   (head_desc),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[hdl/ctabe_front.sv]
module ctabe_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ctabe_pkg::IN_W-1:0]   s_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [ctabe_pkg::CFG_W-1:0]  cfg_data,
    input  logic                         q_full,
    output logic                         q_push,
    output ctabe_pkg::desc_t             q_desc
);

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [1:0]      last;
    } utf8_t;

    logic [11:0]     columns_reg, rows_reg;
    logic [11:0]     col_reg, col_next;
    logic [11:0]     row_reg, row_next;
    logic [3:0][3:0] row_bcd_reg, row_bcd_next;
    logic            color_sent_reg, color_sent_next;
    logic [23:0]     sent_fore_reg, sent_back_reg;

    logic [31:0] cp;
    logic [23:0] fg, bg;
    logic [11:0] ncol, nrow;
    logic        col_end, row_end, frame_end, home, sent_valid, need, accept;
    utf8_t       enc;

    function automatic logic [11:0] eff_side(input logic [11:0] v);
        if (v == 12'd0) begin
            return 12'd1;
        end else if (32'(v) > ctabe_pkg::MAX_SIDE) begin
            return 12'(ctabe_pkg::MAX_SIDE);
        end
        return v;
    endfunction

    function automatic ctabe_pkg::dec3_t dec3(input logic [7:0] v);
        logic [1:0]      h;
        logic [6:0]      r;
        logic [14:0]     p;
        logic [3:0]      t, o;
        ctabe_pkg::dec3_t d;
        if (v >= 8'd200) begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end else begin
            h = 2'd0;
            r = v[6:0];
        end
        p = 15'(r) * 15'd205;
        t = p[14:11];
        o = 4'(r - 7'(t) * 7'd10);
        if (h != 2'd0) begin
            d.dig  = {o, t, {2'b00, h}};
            d.last = 2'd2;
        end else if (t != 4'd0) begin
            d.dig  = {4'd0, o, t};
            d.last = 2'd1;
        end else begin
            d.dig  = {4'd0, 4'd0, o};
            d.last = 2'd0;
        end
        return d;
    endfunction

    function automatic utf8_t utf8_enc(input logic [31:0] raw);
        logic [20:0] c;
        utf8_t       u;
        if (raw < 32'h20 || raw == 32'h7f || raw > 32'h10ffff ||
            (raw >= 32'hd800 && raw <= 32'hdfff)) begin
            c = 21'hfffd;
        end else begin
            c = raw[20:0];
        end
        u.b = '0;
        if (c <= 21'h7f) begin
            u.b[0] = c[7:0];
            u.last = 2'd0;
        end else if (c <= 21'h7ff) begin
            u.b[0] = {3'b110, c[10:6]};
            u.b[1] = {2'b10, c[5:0]};
            u.last = 2'd1;
        end else if (c <= 21'hffff) begin
            u.b[0] = {4'b1110, c[15:12]};
            u.b[1] = {2'b10, c[11:6]};
            u.b[2] = {2'b10, c[5:0]};
            u.last = 2'd2;
        end else begin
            u.b[0] = {5'b11110, c[20:18]};
            u.b[1] = {2'b10, c[17:12]};
            u.b[2] = {2'b10, c[11:6]};
            u.b[3] = {2'b10, c[5:0]};
            u.last = 2'd3;
        end
        return u;
    endfunction

    function automatic logic [3:0][3:0] bcd_inc(input logic [3:0][3:0] v);
        logic [3:0][3:0] r;
        logic            carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (carry) begin
                if (r[i] == 4'd9) begin
                    r[i] = 4'd0;
                end else begin
                    r[i]  = r[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && !q_full;
    assign q_push    = accept;

    assign cp = s_tdata[31:0];
    assign fg = s_tdata[55:32];
    assign bg = s_tdata[79:56];

    always_comb begin
        ncol       = eff_side(columns_reg);
        nrow       = eff_side(rows_reg);
        col_end    = ({1'b0, col_reg} + 13'd1) >= {1'b0, ncol};
        row_end    = ({1'b0, row_reg} + 13'd1) >= {1'b0, nrow};
        frame_end  = col_end && row_end;
        home       = (col_reg == 12'd0) && (row_reg == 12'd0);
        sent_valid = color_sent_reg && !home;
        need       = !sent_valid || fg != sent_fore_reg || bg != sent_back_reg;
        enc        = utf8_enc(cp);

        q_desc = '0;
        if (col_reg != 12'd0) begin
            q_desc.hdr = ctabe_pkg::HDR_NONE;
        end else if (row_reg == 12'd0) begin
            q_desc.hdr = ctabe_pkg::HDR_HOME;
        end else begin
            q_desc.hdr = ctabe_pkg::HDR_ROW;
        end
        if (row_bcd_reg[3] != 4'd0) begin
            q_desc.row_dig  = {row_bcd_reg[0], row_bcd_reg[1], row_bcd_reg[2], row_bcd_reg[3]};
            q_desc.row_last = 2'd3;
        end else if (row_bcd_reg[2] != 4'd0) begin
            q_desc.row_dig  = {4'd0, row_bcd_reg[0], row_bcd_reg[1], row_bcd_reg[2]};
            q_desc.row_last = 2'd2;
        end else if (row_bcd_reg[1] != 4'd0) begin
            q_desc.row_dig  = {8'd0, row_bcd_reg[0], row_bcd_reg[1]};
            q_desc.row_last = 2'd1;
        end else begin
            q_desc.row_dig  = {12'd0, row_bcd_reg[0]};
            q_desc.row_last = 2'd0;
        end
        q_desc.color     = need;
        q_desc.col[0]    = dec3(fg[23:16]);
        q_desc.col[1]    = dec3(fg[15:8]);
        q_desc.col[2]    = dec3(fg[7:0]);
        q_desc.col[3]    = dec3(bg[23:16]);
        q_desc.col[4]    = dec3(bg[15:8]);
        q_desc.col[5]    = dec3(bg[7:0]);
        q_desc.utf8      = enc.b;
        q_desc.utf8_last = enc.last;
        q_desc.frame_end = frame_end;

        col_next        = col_reg;
        row_next        = row_reg;
        row_bcd_next    = row_bcd_reg;
        color_sent_next = color_sent_reg;
        if (accept) begin
            color_sent_next = !frame_end;
            if (col_end) begin
                col_next = 12'd0;
                if (row_end) begin
                    row_next     = 12'd0;
                    row_bcd_next = {4'd0, 4'd0, 4'd0, 4'd1};
                end else begin
                    row_next     = row_reg + 12'd1;
                    row_bcd_next = bcd_inc(row_bcd_reg);
                end
            end else begin
                col_next = col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg    <= 12'd80;
            rows_reg       <= 12'd24;
            col_reg        <= '0;
            row_reg        <= '0;
            row_bcd_reg    <= {4'd0, 4'd0, 4'd0, 4'd1};
            color_sent_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            row_bcd_reg    <= row_bcd_next;
            color_sent_reg <= color_sent_next;
            if (cfg_valid) begin
                if (cfg_index == ctabe_pkg::REG_COLUMNS) begin
                    columns_reg <= cfg_data;
                end else begin
                    rows_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && need) begin
            sent_fore_reg <= fg;
            sent_back_reg <= bg;
        end
    end

endmodule

[hdl/ctabe_queue.sv]
module ctabe_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ctabe_pkg::desc_t din,
    output logic             full,
    input  logic             pop,
    output ctabe_pkg::desc_t dout,
    output logic             empty
);

    localparam int DEPTH = 2;

    ctabe_pkg::desc_t mem [DEPTH];
    logic [$clog2(DEPTH)-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(DEPTH):0]   count_reg;

    assign full  = count_reg == ($clog2(DEPTH)+1)'(DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/ctabe_back.sv]
module ctabe_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ctabe_pkg::desc_t             q_desc,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ctabe_pkg::OUT_W-1:0]  m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    typedef enum logic [3:0] {
        P_START,
        P_HOME,
        P_ROWPRE,
        P_ROWDIG,
        P_ROWSUF,
        P_FGPRE,
        P_DIG,
        P_SEP,
        P_BGPRE,
        P_ENDM,
        P_CHAR,
        P_RESET
    } phase_t;

    // ESC [ H ; ESC [ 3 8 ; 2 ; ; m ESC [ 4 8 ; 2 ; ; ; 1 H ; ESC [ 0 m
    localparam logic [2:0][7:0] HOME_STR = {8'h48, 8'h5b, 8'h1b};
    localparam logic [6:0][7:0] FG_STR   = {8'h3b, 8'h32, 8'h3b, 8'h38, 8'h33, 8'h5b, 8'h1b};
    localparam logic [7:0][7:0] BG_STR   = {8'h3b, 8'h32, 8'h3b, 8'h38, 8'h34, 8'h5b, 8'h1b,
                                            8'h6d};
    localparam logic [2:0][7:0] ROW_STR  = {8'h48, 8'h31, 8'h3b};
    localparam logic [3:0][7:0] RST_STR  = {8'h6d, 8'h30, 8'h5b, 8'h1b};
    localparam logic [7:0]      CH_SEMI  = 8'h3b;
    localparam logic [7:0]      CH_M     = 8'h6d;
    localparam logic [7:0]      CH_ZERO  = 8'h30;

    phase_t     phase_reg, phase_next;
    logic [2:0] k_reg, k_next;
    logic [2:0] c_reg, c_next;
    logic       m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [7:0] m_tdata_reg;

    phase_t     cur, after_hdr;
    logic [2:0] kk, cc;
    logic [7:0] byte_val;
    logic       done, advance, work;

    assign advance = !m_tvalid_reg || m_tready;
    assign work    = advance && !q_empty;
    assign q_pop   = work && done;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        after_hdr = q_desc.color ? P_FGPRE : P_CHAR;
        if (phase_reg == P_START) begin
            kk = 3'd0;
            cc = 3'd0;
            unique case (q_desc.hdr)
                ctabe_pkg::HDR_HOME: cur = P_HOME;
                ctabe_pkg::HDR_ROW:  cur = P_ROWPRE;
                default:             cur = after_hdr;
            endcase
        end else begin
            kk  = k_reg;
            cc  = c_reg;
            cur = phase_reg;
        end

        byte_val   = '0;
        phase_next = cur;
        c_next     = cc;
        done       = 1'b0;
        unique case (cur)
            P_HOME: begin
                byte_val = HOME_STR[kk[1:0]];
                if (kk == 3'd2) phase_next = after_hdr;
            end
            P_ROWPRE: begin
                byte_val = HOME_STR[kk[1:0]];
                if (kk == 3'd1) phase_next = P_ROWDIG;
            end
            P_ROWDIG: begin
                byte_val = CH_ZERO | {4'd0, q_desc.row_dig[kk[1:0]]};
                if (kk[1:0] == q_desc.row_last) phase_next = P_ROWSUF;
            end
            P_ROWSUF: begin
                byte_val = ROW_STR[kk[1:0]];
                if (kk == 3'd2) phase_next = after_hdr;
            end
            P_FGPRE: begin
                byte_val = FG_STR[kk];
                if (kk == 3'd6) begin
                    phase_next = P_DIG;
                    c_next     = 3'd0;
                end
            end
            P_DIG: begin
                byte_val = CH_ZERO | {4'd0, q_desc.col[cc].dig[kk[1:0]]};
                if (kk[1:0] == q_desc.col[cc].last) begin
                    if (cc == 3'd2) begin
                        phase_next = P_BGPRE;
                    end else if (cc == 3'd5) begin
                        phase_next = P_ENDM;
                    end else begin
                        phase_next = P_SEP;
                    end
                end
            end
            P_SEP: begin
                byte_val   = CH_SEMI;
                phase_next = P_DIG;
                c_next     = cc + 3'd1;
            end
            P_BGPRE: begin
                byte_val = BG_STR[kk];
                if (kk == 3'd7) begin
                    phase_next = P_DIG;
                    c_next     = 3'd3;
                end
            end
            P_ENDM: begin
                byte_val   = CH_M;
                phase_next = P_CHAR;
            end
            P_CHAR: begin
                byte_val = q_desc.utf8[kk[1:0]];
                if (kk[1:0] == q_desc.utf8_last) begin
                    if (q_desc.frame_end) begin
                        phase_next = P_RESET;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            P_RESET: begin
                byte_val = RST_STR[kk[1:0]];
                if (kk == 3'd3) done = 1'b1;
            end
            default: begin
                byte_val = '0;
            end
        endcase

        if (done) begin
            phase_next = P_START;
        end
        k_next = (done || phase_next != cur) ? 3'd0 : kk + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= P_START;
            k_reg        <= '0;
            c_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= !q_empty;
            if (!q_empty) begin
                phase_reg   <= phase_next;
                k_reg       <= k_next;
                c_reg       <= c_next;
                m_tdata_reg <= byte_val;
                m_tlast_reg <= done;
                m_tuser_reg <= done && q_desc.frame_end;
            end
        end
    end

endmodule

[hdl/ctabe_checker.sv]
module ctabe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_M   = 8'h6d;

    a_frame_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end flagged on a byte that does not end its item");

    a_frame_ends_m: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == CH_M)
        else $error("frame does not end with the attribute reset");

    a_cell_ends_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata != CH_ESC)
        else $error("item ends with an escape byte");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

endmodule

bind cell_to_ansi_byte_encoder_top ctabe_checker u_ctabe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
